>>> sv/srl_pkg.sv
package srl_pkg;

   localparam logic [3:0] PH_START    = 4'd0;
   localparam logic [3:0] PH_TYPE     = 4'd1;
   localparam logic [3:0] PH_COUNT    = 4'd2;
   localparam logic [3:0] PH_ADDR_HI  = 4'd3;
   localparam logic [3:0] PH_ADDR_LO  = 4'd4;
   localparam logic [3:0] PH_ADDR_EXT = 4'd5;
   localparam logic [3:0] PH_DATA     = 4'd6;
   localparam logic [3:0] PH_CHECK    = 4'd7;
   localparam logic [3:0] PH_SKIP     = 4'd8;

   localparam logic [1:0] RT_S1 = 2'd0;
   localparam logic [1:0] RT_S2 = 2'd1;
   localparam logic [1:0] RT_S8 = 2'd2;
   localparam logic [1:0] RT_S9 = 2'd3;

   localparam logic [1:0] KIND_WRITE = 2'd0;
   localparam logic [1:0] KIND_RANGE = 2'd1;
   localparam logic [1:0] KIND_START = 2'd2;
   localparam logic [1:0] KIND_ERROR = 2'd3;

   localparam logic [1:0] ERR_LINE_START = 2'd0;
   localparam logic [1:0] ERR_FORMAT     = 2'd1;
   localparam logic [1:0] ERR_CHECKSUM   = 2'd2;

   localparam logic [1:0] CPU_MODE_WIDE = 2'd2;

   localparam logic [7:0] CH_S       = 8'h53;
   localparam logic [7:0] CH_ONE     = 8'h31;
   localparam logic [7:0] CH_TWO     = 8'h32;
   localparam logic [7:0] CH_EIGHT   = 8'h38;
   localparam logic [7:0] CH_NINE    = 8'h39;
   localparam logic [7:0] CH_NEWLINE = 8'h0A;

   localparam logic [7:0]  SUM_GOOD  = 8'hFF;
   localparam logic [15:0] LINE_MAX  = 16'hFFFF;
   localparam logic [24:0] S1_ADDR_MAX = 25'h000FFFF;

   typedef struct packed {
      logic [3:0]  phase;
      logic [1:0]  record_type;
      logic        type_ok;
      logic [3:0]  high_nibble;
      logic        nibble_pending;
      logic [7:0]  bytes_left;
      logic [24:0] cur_address;
      logic [23:0] range_start;
      logic        had_data;
      logic [7:0]  running_sum;
      logic [15:0] line_count;
      logic        halted;
   } state_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [23:0] address;
      logic [23:0] end_address;
      logic [7:0]  data;
      logic [1:0]  error_code;
      logic [15:0] line_number;
   } result_type;

   // {valid, value}
   function automatic logic [4:0] hex_digit(input logic [7:0] c);
      logic [4:0] r;
      r = '0;
      if (c >= 8'h30 && c <= 8'h39) begin
         r = {1'b1, c[3:0]};
      end else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
         r = {1'b1, c[3:0] + 4'd9};
      end
      return r;
   endfunction

endpackage

>>> sv/srl_step.sv
module srl_step (
   input  logic [1:0]          cpu_mode,
   input  logic [7:0]          char_in,
   input  srl_pkg::state_type  cur,
   output srl_pkg::state_type  nxt,
   output logic                emit,
   output srl_pkg::result_type res
);
   import srl_pkg::*;

   logic [4:0] hv;
   logic [7:0] byte_v;
   logic [7:0] sum;
   logic       fail;
   logic [1:0] fail_code;
   logic [7:0] left_dec;
   logic [24:0] addr_dec;

   always_comb begin
      nxt       = cur;
      res       = '0;
      emit      = 1'b0;
      fail      = 1'b0;
      fail_code = ERR_FORMAT;
      hv        = hex_digit(char_in);
      byte_v    = {cur.high_nibble, hv[3:0]};
      sum       = cur.running_sum + byte_v;
      left_dec  = cur.bytes_left - 8'd1;
      addr_dec  = cur.cur_address - 25'd1;
      res.line_number = cur.line_count;

      if (!cur.halted) begin
         unique case (cur.phase)
            PH_START: begin
               if (char_in != CH_S) begin
                  fail      = 1'b1;
                  fail_code = ERR_LINE_START;
               end else begin
                  nxt.phase = PH_TYPE;
               end
            end
            PH_TYPE: begin
               if (char_in == CH_NEWLINE) begin
                  fail = 1'b1;
               end else begin
                  nxt.type_ok = 1'b1;
                  priority if (char_in == CH_ONE) begin
                     nxt.record_type = RT_S1;
                  end else if (char_in == CH_TWO) begin
                     nxt.record_type = RT_S2;
                  end else if (char_in == CH_EIGHT) begin
                     nxt.record_type = RT_S8;
                  end else if (char_in == CH_NINE) begin
                     nxt.record_type = RT_S9;
                  end else begin
                     nxt.record_type = RT_S1;
                     nxt.type_ok     = 1'b0;
                  end
                  nxt.running_sum    = '0;
                  nxt.nibble_pending = 1'b0;
                  nxt.phase          = PH_COUNT;
               end
            end
            PH_SKIP: begin
               if (char_in == CH_NEWLINE) begin
                  if (cur.line_count != LINE_MAX) begin
                     nxt.line_count = cur.line_count + 16'd1;
                  end
                  nxt.phase = PH_START;
               end
            end
            default: begin
               priority if (cur.phase == PH_DATA && !cur.nibble_pending &&
                            cur.record_type == RT_S1 && cur.cur_address > S1_ADDR_MAX) begin
                  fail = 1'b1;
               end else if (!hv[4]) begin
                  fail = 1'b1;
               end else if (!cur.nibble_pending) begin
                  nxt.high_nibble    = hv[3:0];
                  nxt.nibble_pending = 1'b1;
               end else begin
                  nxt.nibble_pending = 1'b0;
                  nxt.running_sum    = sum;
                  unique case (cur.phase)
                     PH_COUNT: begin
                        if (byte_v < 8'd3) begin
                           fail = 1'b1;
                        end else begin
                           nxt.bytes_left = byte_v - 8'd3;
                           nxt.phase      = PH_ADDR_HI;
                        end
                     end
                     PH_ADDR_HI: begin
                        nxt.cur_address = {9'd0, byte_v, 8'd0};
                        nxt.phase       = PH_ADDR_LO;
                     end
                     PH_ADDR_LO: begin
                        nxt.cur_address = {cur.cur_address[24:8], byte_v};
                        priority if (!cur.type_ok) begin
                           fail = 1'b1;
                        end else if (cur.record_type == RT_S1) begin
                           nxt.had_data    = cur.bytes_left != 8'd0;
                           nxt.range_start = {cur.cur_address[23:8], byte_v};
                           nxt.phase       = (cur.bytes_left != 8'd0) ? PH_DATA : PH_CHECK;
                        end else if (cur.record_type == RT_S9) begin
                           if (cur.bytes_left != 8'd0) begin
                              fail = 1'b1;
                           end else begin
                              nxt.phase = PH_CHECK;
                           end
                        end else if (cur.record_type == RT_S2 && cpu_mode != CPU_MODE_WIDE) begin
                           fail = 1'b1;
                        end else if (cur.bytes_left == 8'd0) begin
                           fail = 1'b1;
                        end else begin
                           nxt.bytes_left = left_dec;
                           nxt.phase      = PH_ADDR_EXT;
                        end
                     end
                     PH_ADDR_EXT: begin
                        nxt.cur_address = {cur.cur_address[16:0], byte_v};
                        if (cur.record_type == RT_S8) begin
                           if (cur.bytes_left != 8'd0) begin
                              fail = 1'b1;
                           end else begin
                              nxt.phase = PH_CHECK;
                           end
                        end else begin
                           nxt.had_data    = cur.bytes_left != 8'd0;
                           nxt.range_start = {cur.cur_address[15:0], byte_v};
                           nxt.phase       = (cur.bytes_left != 8'd0) ? PH_DATA : PH_CHECK;
                        end
                     end
                     PH_DATA: begin
                        nxt.cur_address = cur.cur_address + 25'd1;
                        nxt.bytes_left  = left_dec;
                        if (left_dec == 8'd0) begin
                           nxt.phase = PH_CHECK;
                        end
                        emit        = 1'b1;
                        res.kind    = KIND_WRITE;
                        res.address = cur.cur_address[23:0];
                        res.data    = byte_v;
                     end
                     PH_CHECK: begin
                        if (sum != SUM_GOOD) begin
                           fail      = 1'b1;
                           fail_code = ERR_CHECKSUM;
                        end else begin
                           nxt.phase = PH_SKIP;
                           if (cur.record_type == RT_S8 || cur.record_type == RT_S9) begin
                              emit        = 1'b1;
                              res.kind    = KIND_START;
                              res.address = cur.cur_address[23:0];
                           end else if (cur.had_data) begin
                              emit            = 1'b1;
                              res.kind        = KIND_RANGE;
                              res.address     = cur.range_start;
                              res.end_address = addr_dec[23:0];
                           end
                        end
                     end
                     default: begin
                     end
                  endcase
               end
            end
         endcase

         if (fail) begin
            nxt.halted      = 1'b1;
            emit            = 1'b1;
            res             = '0;
            res.kind        = KIND_ERROR;
            res.error_code  = fail_code;
            res.line_number = cur.line_count;
         end
      end
   end

endmodule

>>> sv/srec_record_loader_core.sv
// S-record loader: takes one character per beat on req_ and parses S1/S2/S8/S9 lines
// (newline 0x0A ends a line, hex digits in either case). Each data byte gives a write
// beat on rsp_, a good S1/S2 checksum gives the loaded address range and S8/S9 gives the
// start address. The first error gives one error beat and the core then swallows all
// characters until reset. One character is taken every cycle: the parser next state is
// combinational and results go through one output register, so req_ready only drops
// while a result sits unaccepted. csr_wdata sets the CPU mode (2 enables S2 records);
// write it only while the core is idle.
module srec_record_loader_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_we,
   input  logic [1:0]  csr_wdata,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_char_in,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_kind,
   output logic [23:0] rsp_address,
   output logic [23:0] rsp_end_address,
   output logic [7:0]  rsp_data,
   output logic [1:0]  rsp_error_code,
   output logic [15:0] rsp_line_number
);
   import srl_pkg::*;

   localparam state_type STATE_RESET = '{
      phase:          PH_START,
      record_type:    RT_S1,
      type_ok:        1'b0,
      high_nibble:    4'd0,
      nibble_pending: 1'b0,
      bytes_left:     8'd0,
      cur_address:    25'd0,
      range_start:    24'd0,
      had_data:       1'b0,
      running_sum:    8'd0,
      line_count:     16'd1,
      halted:         1'b0
   };

   logic [1:0] cpu_mode_ff;
   state_type  state_ff;
   state_type  state_in;
   logic       emit;
   result_type res_in;
   result_type res_ff;
   logic       rsp_valid_ff;
   logic       accept;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;

   srl_step u_step (
      .cpu_mode (cpu_mode_ff),
      .char_in  (req_char_in),
      .cur      (state_ff),
      .nxt      (state_in),
      .emit     (emit),
      .res      (res_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         cpu_mode_ff  <= '0;
         state_ff     <= STATE_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            cpu_mode_ff <= csr_wdata;
         end
         if (accept) begin
            state_ff <= state_in;
         end
         if (accept && emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept && emit) begin
         res_ff <= res_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_kind        = res_ff.kind;
   assign rsp_address     = res_ff.address;
   assign rsp_end_address = res_ff.end_address;
   assign rsp_data        = res_ff.data;
   assign rsp_error_code  = res_ff.error_code;
   assign rsp_line_number = res_ff.line_number;

endmodule

>>> tb/srec_record_loader_core_test.sv
module srec_record_loader_core_test;
   timeunit 1ns;
   timeprecision 1ps;

   import srl_pkg::*;

   localparam int HOLD_CYCLES    = 200;
   localparam int SETTLE_CYCLES  = 4;
   localparam int DRAIN_CYCLES   = 100;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int PHASE_CHARS    = 190;
   localparam int MAX_SHOWN      = 10;
   localparam int MIN_COUNT      = 3;

   typedef enum int {
      FAULT_LINE_START,
      FAULT_TYPE_NEWLINE,
      FAULT_BAD_TYPE,
      FAULT_BAD_DIGIT,
      FAULT_EARLY_NEWLINE,
      FAULT_SHORT_COUNT,
      FAULT_SHORT_WIDE,
      FAULT_S2_DENIED,
      FAULT_EXTRA_BYTES,
      FAULT_S1_WRAP,
      FAULT_CHECKSUM
   } fault_type;

   typedef struct {
      string      text;
      bit         typed;
      result_type want;
   } dir_row_type;

   logic        clock;
   logic        reset       = 1'b1;
   logic        csr_we      = 1'b0;
   logic [1:0]  csr_wdata   = 2'd0;
   logic        req_valid   = 1'b0;
   logic        req_ready;
   logic [7:0]  req_char_in = 8'd0;
   logic        rsp_valid;
   logic        rsp_ready   = 1'b0;
   logic [1:0]  rsp_kind;
   logic [23:0] rsp_address;
   logic [23:0] rsp_end_address;
   logic [7:0]  rsp_data;
   logic [1:0]  rsp_error_code;
   logic [15:0] rsp_line_number;

   srec_record_loader_core u_dut (
      .clock           (clock),
      .reset           (reset),
      .csr_we          (csr_we),
      .csr_wdata       (csr_wdata),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_char_in     (req_char_in),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_kind        (rsp_kind),
      .rsp_address     (rsp_address),
      .rsp_end_address (rsp_end_address),
      .rsp_data        (rsp_data),
      .rsp_error_code  (rsp_error_code),
      .rsp_line_number (rsp_line_number)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // loader state as the parser sees it
   logic [1:0]  ld_mode     = 2'd0;
   logic [3:0]  ld_stage    = PH_START;
   logic [1:0]  ld_rtype    = RT_S1;
   bit          ld_type_ok  = 1'b0;
   logic [3:0]  ld_hi       = 4'd0;
   bit          ld_hi_held  = 1'b0;
   logic [7:0]  ld_left     = 8'd0;
   logic [24:0] ld_addr     = 25'd0;
   logic [23:0] ld_base     = 24'd0;
   bit          ld_any_data = 1'b0;
   logic [7:0]  ld_sum      = 8'd0;
   logic [15:0] ld_line     = 16'd1;
   bit          ld_halt     = 1'b0;

   result_type  due_beats [$];
   logic [7:0]  line_buf [$];
   dir_row_type dir_table [8];
   logic [1:0]  phase_modes [5] = '{2'd0, 2'd3, CPU_MODE_WIDE, 2'd1, CPU_MODE_WIDE};

   bit          beat_typed = 1'b0;
   result_type  beat_want  = '0;
   int          chars_sent = 0;
   int          tx_burst   = 0;
   int          rx_burst   = 0;
   bit          hold_req   = 1'b0;
   int          fault_count = 0;
   int          quiet      = 0;

   bit          produced;
   bit          took_char;
   bit          gave_beat;
   result_type  predicted;
   result_type  observed;
   result_type  expected_beat;

   function automatic int hex_val(input logic [7:0] c);
      if (c >= "0" && c <= "9") return c - "0";
      if (c >= "A" && c <= "F") return c - "A" + 10;
      if (c >= "a" && c <= "f") return c - "a" + 10;
      return -1;
   endfunction

   function automatic logic [7:0] hex_char(input logic [3:0] n);
      if (n < 10) return "0" + n;
      return ((($urandom_range(0, 1) != 0) ? "A" : "a") + n - 10);
   endfunction

   function automatic result_type make_beat(input logic [1:0] kind, input logic [23:0] a,
                                            input logic [23:0] e, input logic [7:0] d);
      result_type r;
      r = '0;
      r.kind        = kind;
      r.address     = a;
      r.end_address = e;
      r.data        = d;
      r.line_number = ld_line;
      return r;
   endfunction

   function automatic result_type start_beat(input logic [23:0] a, input logic [15:0] ln);
      result_type r;
      r = '0;
      r.kind        = KIND_START;
      r.address     = a;
      r.line_number = ln;
      return r;
   endfunction

   function automatic bit halt_with(input logic [1:0] code, output result_type r);
      ld_halt = 1'b1;
      r = make_beat(KIND_ERROR, 24'h0, 24'h0, 8'h0);
      r.error_code = code;
      return 1'b1;
   endfunction

   function automatic bit eat_byte(input logic [7:0] b, output result_type r);
      logic [24:0] spot;
      r = '0;
      ld_sum = ld_sum + b;
      case (ld_stage)
         PH_COUNT: begin
            if (b < MIN_COUNT) return halt_with(ERR_FORMAT, r);
            ld_left  = b - MIN_COUNT;
            ld_stage = PH_ADDR_HI;
         end
         PH_ADDR_HI: begin
            ld_addr  = {9'd0, b, 8'd0};
            ld_stage = PH_ADDR_LO;
         end
         PH_ADDR_LO: begin
            ld_addr[7:0] = b;
            if (!ld_type_ok) return halt_with(ERR_FORMAT, r);
            if (ld_rtype == RT_S1) begin
               ld_any_data = ld_left != 0;
               ld_base     = ld_addr[23:0];
               ld_stage    = ld_any_data ? PH_DATA : PH_CHECK;
            end else if (ld_rtype == RT_S9) begin
               if (ld_left != 0) return halt_with(ERR_FORMAT, r);
               ld_stage = PH_CHECK;
            end else begin
               if (ld_rtype == RT_S2 && ld_mode != CPU_MODE_WIDE) return halt_with(ERR_FORMAT, r);
               if (ld_left == 0) return halt_with(ERR_FORMAT, r);
               ld_left  = ld_left - 8'd1;
               ld_stage = PH_ADDR_EXT;
            end
         end
         PH_ADDR_EXT: begin
            ld_addr = {ld_addr[16:0], b};
            if (ld_rtype == RT_S8) begin
               if (ld_left != 0) return halt_with(ERR_FORMAT, r);
               ld_stage = PH_CHECK;
            end else begin
               ld_any_data = ld_left != 0;
               ld_base     = ld_addr[23:0];
               ld_stage    = ld_any_data ? PH_DATA : PH_CHECK;
            end
         end
         PH_DATA: begin
            spot    = ld_addr;
            ld_addr = ld_addr + 25'd1;
            ld_left = ld_left - 8'd1;
            if (ld_left == 0) ld_stage = PH_CHECK;
            r = make_beat(KIND_WRITE, spot[23:0], 24'h0, b);
            return 1'b1;
         end
         PH_CHECK: begin
            if (ld_sum != SUM_GOOD) return halt_with(ERR_CHECKSUM, r);
            ld_stage = PH_SKIP;
            if (ld_rtype == RT_S8 || ld_rtype == RT_S9) begin
               r = make_beat(KIND_START, ld_addr[23:0], 24'h0, 8'h0);
               return 1'b1;
            end
            if (ld_any_data) begin
               spot = ld_addr - 25'd1;
               r = make_beat(KIND_RANGE, ld_base, spot[23:0], 8'h0);
               return 1'b1;
            end
         end
         default: ;
      endcase
      return 1'b0;
   endfunction

   function automatic bit loader_step(input logic [7:0] c, output result_type r);
      int v;
      r = '0;
      if (ld_halt) return 1'b0;
      case (ld_stage)
         PH_START: begin
            if (c != CH_S) return halt_with(ERR_LINE_START, r);
            ld_stage = PH_TYPE;
            return 1'b0;
         end
         PH_TYPE: begin
            if (c == CH_NEWLINE) return halt_with(ERR_FORMAT, r);
            ld_type_ok = 1'b1;
            case (c)
               CH_ONE:   ld_rtype = RT_S1;
               CH_TWO:   ld_rtype = RT_S2;
               CH_EIGHT: ld_rtype = RT_S8;
               CH_NINE:  ld_rtype = RT_S9;
               default: begin
                  ld_rtype   = RT_S1;
                  ld_type_ok = 1'b0;
               end
            endcase
            ld_sum     = 8'd0;
            ld_hi_held = 1'b0;
            ld_stage   = PH_COUNT;
            return 1'b0;
         end
         PH_SKIP: begin
            if (c == CH_NEWLINE) begin
               if (ld_line != LINE_MAX) ld_line = ld_line + 16'd1;
               ld_stage = PH_START;
            end
            return 1'b0;
         end
         default: ;
      endcase
      // an S1 byte due past the 16-bit space fails on its first character
      if (ld_stage == PH_DATA && !ld_hi_held && ld_rtype == RT_S1 && ld_addr > S1_ADDR_MAX)
         return halt_with(ERR_FORMAT, r);
      v = hex_val(c);
      if (v < 0) return halt_with(ERR_FORMAT, r);
      if (!ld_hi_held) begin
         ld_hi      = v[3:0];
         ld_hi_held = 1'b1;
         return 1'b0;
      end
      ld_hi_held = 1'b0;
      return eat_byte({ld_hi, v[3:0]}, r);
   endfunction

   function automatic int pick_gap(inout int burst);
      int r;
      if (burst > 0) begin
         burst--;
         return 0;
      end
      r = $urandom_range(0, 99);
      if (r < 2) begin
         burst = $urandom_range(20, 120);
         return 0;
      end
      if (r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 98) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   task automatic log_fault(input string what, input result_type w, input result_type g);
      fault_count++;
      if (fault_count <= MAX_SHOWN)
         $display("%0t %s: want kind=%0d addr=%h end=%h data=%h code=%0d line=%0d,",
                  $realtime, what, w.kind, w.address, w.end_address, w.data, w.error_code,
                  w.line_number,
                  " got kind=%0d addr=%h end=%h data=%h code=%0d line=%0d",
                  g.kind, g.address, g.end_address, g.data, g.error_code, g.line_number);
   endtask

   always @(posedge clock) begin
      if (!reset) begin
         took_char = req_valid && req_ready;
         gave_beat = rsp_valid && rsp_ready;
         if (took_char) begin
            produced = loader_step(req_char_in, predicted);
            if (beat_typed) due_beats.push_back(beat_want);
            else if (produced) due_beats.push_back(predicted);
         end
         if (gave_beat) begin
            observed = {rsp_kind, rsp_address, rsp_end_address, rsp_data, rsp_error_code,
                        rsp_line_number};
            if (due_beats.size() == 0) begin
               log_fault("unexpected beat", '0, observed);
            end else begin
               expected_beat = due_beats.pop_front();
               if (expected_beat !== observed) log_fault("beat mismatch", expected_beat, observed);
            end
         end
         quiet = (took_char || gave_beat) ? 0 : quiet + 1;
         if (quiet >= WATCHDOG_LIMIT) begin
            $display("Regression FAIL");
            $finish;
         end
      end
   end

   initial begin
      int idle;
      forever begin
         @(negedge clock);
         idle = pick_gap(rx_burst);
         if (hold_req) begin
            hold_req = 1'b0;
            idle += HOLD_CYCLES;
         end
         if (idle > 0) begin
            rsp_ready <= 1'b0;
            repeat (idle) @(negedge clock);
         end
         rsp_ready <= 1'b1;
      end
   end

   task automatic send_char(input logic [7:0] c, input bit typed, input result_type want);
      int idle;
      idle = pick_gap(tx_burst);
      if (idle > 0) begin
         req_valid <= 1'b0;
         repeat (idle) @(negedge clock);
      end
      req_char_in <= c;
      req_valid   <= 1'b1;
      beat_typed = typed;
      beat_want  = want;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      chars_sent++;
      @(negedge clock);
   endtask

   task automatic send_buf();
      foreach (line_buf[i]) send_char(line_buf[i], 1'b0, '0);
   endtask

   task automatic send_text(input string s, input bit typed, input result_type want);
      for (int i = 0; i < s.len(); i++) send_char(s[i], typed && i == s.len() - 1, want);
      send_char(CH_NEWLINE, 1'b0, '0);
   endtask

   task automatic drain(input int settle);
      req_valid <= 1'b0;
      while (due_beats.size() != 0) @(negedge clock);
      repeat (settle) @(negedge clock);
   endtask

   task automatic set_mode(input logic [1:0] m);
      drain(SETTLE_CYCLES);
      csr_wdata <= m;
      csr_we    <= 1'b1;
      @(negedge clock);
      csr_we <= 1'b0;
      ld_mode = m;
   endtask

   task automatic push_hex(input logic [7:0] b);
      line_buf.push_back(hex_char(b[7:4]));
      line_buf.push_back(hex_char(b[3:0]));
   endtask

   // count < 0 means the count that matches the bytes
   task automatic build_record(input logic [7:0] tc, input int alen, input logic [23:0] a,
                               input int n, input int count, input bit bad_sum);
      logic [7:0] sum;
      logic [7:0] b;
      line_buf.delete();
      line_buf.push_back(CH_S);
      line_buf.push_back(tc);
      b = (count < 0) ? n + alen + 1 : count;
      sum = b;
      push_hex(b);
      for (int i = alen - 1; i >= 0; i--) begin
         b = a[8*i +: 8];
         sum += b;
         push_hex(b);
      end
      for (int i = 0; i < n; i++) begin
         b = $urandom_range(0, 255);
         sum += b;
         push_hex(b);
      end
      b = ~sum;
      if (bad_sum) b ^= $urandom_range(1, 255);
      push_hex(b);
   endtask

   task automatic finish_line(input bit junk);
      logic [7:0] c;
      if (junk) begin
         repeat ($urandom_range(1, 4)) begin
            c = CH_NEWLINE;
            while (c == CH_NEWLINE) c = $urandom_range(0, 255);
            line_buf.push_back(c);
         end
      end
      line_buf.push_back(CH_NEWLINE);
   endtask

   task automatic pick_record(input bit bad_sum);
      int r;
      int n;
      int pick;
      int alen;
      logic [7:0] tc;
      logic [23:0] a;
      r = $urandom_range(0, 99);
      if (r < 6) n = 0;
      else if (r < 97) n = $urandom_range(1, 16);
      else if (r < 99) n = $urandom_range(17, 64);
      else n = 252;
      pick = $urandom_range(0, 99);
      if (ld_mode != CPU_MODE_WIDE) pick = (pick < 65) ? 0 : (pick < 80) ? 80 : 90;
      if (pick < 40) begin
         tc = CH_ONE;
         alen = 2;
         if (n == 0) a = $urandom_range(0, 16'hFFFF);
         else if ($urandom_range(0, 9) == 0) a = 17'h10000 - n;
         else a = $urandom_range(0, 17'h10000 - n);
      end else if (pick < 75) begin
         tc = CH_TWO;
         alen = 3;
         if (n > 251) n = 251;
         a = $urandom();
         if ($urandom_range(0, 9) == 0) a = 24'hFFFFFF - $urandom_range(0, 8);
      end else if (pick < 85) begin
         tc = CH_EIGHT;
         alen = 3;
         n = 0;
         a = $urandom();
      end else begin
         tc = CH_NINE;
         alen = 2;
         n = 0;
         a = $urandom_range(0, 16'hFFFF);
      end
      build_record(tc, alen, a, n, -1, bad_sum);
   endtask

   task automatic fault_tail();
      fault_type f;
      int k;
      int p;
      logic [7:0] c;
      logic [1:0] m;
      f = fault_type'($urandom_range(0, FAULT_CHECKSUM));
      m = $urandom_range(0, 3);
      if (f == FAULT_S2_DENIED) while (m == CPU_MODE_WIDE) m = $urandom_range(0, 3);
      if (f == FAULT_SHORT_WIDE) m = CPU_MODE_WIDE;
      set_mode(m);
      case (f)
         FAULT_LINE_START: begin
            c = CH_S;
            while (c == CH_S) c = $urandom_range(0, 255);
            line_buf.delete();
            line_buf.push_back(c);
         end
         FAULT_TYPE_NEWLINE: begin
            line_buf.delete();
            line_buf.push_back(CH_S);
            line_buf.push_back(CH_NEWLINE);
         end
         FAULT_BAD_TYPE: begin
            c = CH_ONE;
            while (c inside {CH_ONE, CH_TWO, CH_EIGHT, CH_NINE, CH_NEWLINE})
               c = $urandom_range(0, 255);
            build_record(c, 2, $urandom_range(0, 16'hFFFF), $urandom_range(0, 4), -1, 1'b0);
         end
         FAULT_BAD_DIGIT, FAULT_EARLY_NEWLINE: begin
            build_record(CH_ONE, 2, $urandom_range(0, 16'hFF00), $urandom_range(0, 6), -1, 1'b0);
            p = $urandom_range(2, line_buf.size() - 1);
            if (f == FAULT_EARLY_NEWLINE) begin
               c = CH_NEWLINE;
            end else begin
               c = CH_NEWLINE;
               while (hex_val(c) >= 0 || c == CH_NEWLINE) c = $urandom_range(0, 255);
            end
            line_buf[p] = c;
         end
         FAULT_SHORT_COUNT:
            build_record(($urandom_range(0, 1) != 0) ? CH_ONE : CH_NINE, 2,
                         $urandom_range(0, 16'hFFFF), 0, $urandom_range(0, MIN_COUNT - 1), 1'b0);
         FAULT_SHORT_WIDE:
            build_record(($urandom_range(0, 1) != 0) ? CH_TWO : CH_EIGHT, 3, $urandom(), 0,
                         MIN_COUNT, 1'b0);
         FAULT_S2_DENIED:
            build_record(CH_TWO, 3, $urandom(), $urandom_range(0, 4), -1, 1'b0);
         FAULT_EXTRA_BYTES: begin
            if ($urandom_range(0, 1) != 0)
               build_record(CH_NINE, 2, $urandom_range(0, 16'hFFFF), $urandom_range(1, 4),
                            -1, 1'b0);
            else
               build_record(CH_EIGHT, 3, $urandom(), $urandom_range(1, 4), -1, 1'b0);
         end
         FAULT_S1_WRAP: begin
            k = $urandom_range(1, 4);
            build_record(CH_ONE, 2, 17'h10000 - k, k + $urandom_range(1, 3), -1, 1'b0);
         end
         default: pick_record(1'b1);
      endcase
      finish_line(1'b0);
      // the core halts on the faulty line above, so this is swallowed
      repeat (16) line_buf.push_back($urandom_range(0, 255));
      send_buf();
   endtask

   initial begin
      int start;
      dir_table[0] = '{"S9030000FC", 1'b1, start_beat(24'h000000, 16'd1)};
      dir_table[1] = '{"S105fffeabcd85", 1'b0, '0};
      dir_table[2] = '{"S208FFFFFE01020304F1", 1'b0, '0};
      dir_table[3] = '{"S1030000FC", 1'b0, '0};
      dir_table[4] = '{"S204000000FB", 1'b0, '0};
      dir_table[5] = '{"S804FFFFFFFE", 1'b1, start_beat(24'hFFFFFF, 16'd6)};
      dir_table[6] = '{"S903FFFFFE", 1'b1, start_beat(24'h00FFFF, 16'd7)};
      dir_table[7] = '{"S105123400FFB5 junk", 1'b0, '0};

      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      set_mode(CPU_MODE_WIDE);
      foreach (dir_table[i]) send_text(dir_table[i].text, dir_table[i].typed, dir_table[i].want);

      for (int p = 0; p < 5; p++) begin
         set_mode(phase_modes[p]);
         if (p == 2) hold_req = 1'b1;
         start = chars_sent;
         while (chars_sent - start < PHASE_CHARS) begin
            pick_record(1'b0);
            finish_line($urandom_range(0, 4) == 0);
            send_buf();
         end
      end

      fault_tail();
      drain(DRAIN_CYCLES);
      if (fault_count == 0 && due_beats.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
